/* sv/spr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the stop posture ramp sequencer.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int NUM_JOINTS_DEF = 12;
    localparam int POS_WIDTH_DEF  = 16;

    localparam int JIDX_W  = 4;   // joint_index / target_joint field
    localparam int REQ_W   = 2;
    localparam int PHASE_W = 2;
    localparam int STEPS_W = 16;
    localparam int CFG_ADDR_W = 1;

    localparam logic [STEPS_W-1:0] STEPS_RESET = 16'd100;

    // Highest phase code that may appear on a result beat
    localparam logic [PHASE_W-1:0] OUT_PH_HOLD = 2'd2;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK    = 2'd0,
        REQ_CAPTURE = 2'd1,
        REQ_CANCEL  = 2'd2,
        REQ_LOAD    = 2'd3
    } req_e_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE  = 2'd0,
        PH_STAND = 2'd1,
        PH_DOWN  = 2'd2,
        PH_HOLD  = 2'd3
    } stop_phase_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STEPS_STAND = 1'b0,
        REG_STEPS_DOWN  = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        TBL_START = 2'd0,
        TBL_STAND = 2'd1,
        TBL_DOWN  = 2'd2
    } pose_tbl_t;

    typedef struct packed {
        logic      en;
        pose_tbl_t tbl;
    } tbl_wr_t;

endpackage

/* sv/spr_pose_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_pose_table
// Start, stand and down pose tables, one write port, read at the joint index.
// ----------------------------------------------------------------------------
module spr_pose_table #(
    parameter  int NUM_JOINTS = spr_pkg::NUM_JOINTS_DEF,
    parameter  int POS_WIDTH  = spr_pkg::POS_WIDTH_DEF,
    localparam int IDX_W      = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1
) (
    input  logic                 aclk,
    input  spr_pkg::tbl_wr_t     wr,
    input  logic [IDX_W-1:0]     wr_idx,
    input  logic [POS_WIDTH-1:0] wr_data,
    input  logic [IDX_W-1:0]     rd_idx,
    output logic [POS_WIDTH-1:0] start_q,
    output logic [POS_WIDTH-1:0] stand_q,
    output logic [POS_WIDTH-1:0] down_q
);
    import spr_pkg::*;

    logic [POS_WIDTH-1:0] start_mem [NUM_JOINTS];
    logic [POS_WIDTH-1:0] stand_mem [NUM_JOINTS];
    logic [POS_WIDTH-1:0] down_mem  [NUM_JOINTS];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            unique case (wr.tbl)
                TBL_START: start_mem[wr_idx] <= wr_data;
                TBL_STAND: stand_mem[wr_idx] <= wr_data;
                TBL_DOWN:  down_mem[wr_idx]  <= wr_data;
                default: ;
            endcase
        end
    end

    assign start_q = start_mem[rd_idx];
    assign stand_q = stand_mem[rd_idx];
    assign down_q  = down_mem[rd_idx];

endmodule

/* sv/spr_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_divider
// Restoring unsigned divider, one quotient bit per cycle. The caller
// guarantees the quotient fits in Q_W bits.
// ----------------------------------------------------------------------------
module spr_divider #(
    parameter  int Q_W   = spr_pkg::POS_WIDTH_DEF,
    parameter  int DVS_W = spr_pkg::STEPS_W,
    localparam int DVD_W = Q_W + DVS_W,
    localparam int CNT_W = $clog2(Q_W + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [Q_W-1:0]   quotient
);
    import spr_pkg::*;

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] trial_sub;
    logic           fits;

    // Shift the next dividend bit into the partial remainder
    assign trial     = {rem_reg, q_reg[Q_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = trial >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend[DVD_W-1:Q_W];
            q_next    = dividend[Q_W-1:0];
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
            q_next   = {q_reg[Q_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(Q_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* sv/stop_posture_ramp_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_posture_ramp_sequencer
// Controlled-stop posture generator: ramps every joint from a captured pose
// to the stand pose, then to the down pose, and holds there.
// ----------------------------------------------------------------------------
// Input beats on s_axis carry a request in tuser: tick, capture, cancel or
// load. Capture, cancel and load beats keep s_axis_tready high and give no result.
// A tick outside idle gives NUM_JOINTS result beats on m_axis, joint 0
// first, tlast on the final joint; tuser carries the phase used.
// Each joint goes through fetch, one multiply, a shared bit-serial divider
// and an output load, one joint after the other; s_axis_tready stays low
// until the tick's last joint is loaded. A tick in idle gives no result.
// A result waits in the output register while the receiver stalls; the next
// joint is computed behind it and then holds until the register drains.
// Reset puts the sequence in idle, clears the step count and sets both step
// registers to 100. The pose tables are not cleared; entries are valid once
// loaded or captured. The step registers are written through cfg_*; the
// user writes them only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module stop_posture_ramp_sequencer #(
    parameter  int NUM_JOINTS = spr_pkg::NUM_JOINTS_DEF,
    parameter  int POS_WIDTH  = spr_pkg::POS_WIDTH_DEF,
    localparam int DATA_W     = ((spr_pkg::JIDX_W + POS_WIDTH + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [spr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [spr_pkg::STEPS_W-1:0]    cfg_wr_data,
    // request channel
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [DATA_W-1:0]              s_axis_tdata,  // joint_index, position
    input  logic [2:0]                     s_axis_tuser,  // req_type, pose_select
    input  logic                           s_axis_tlast,  // capture_last
    // target channel
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [DATA_W-1:0]              m_axis_tdata,  // target_joint, target_position
    output logic [spr_pkg::PHASE_W-1:0]    m_axis_tuser,  // phase
    output logic                           m_axis_tlast   // last_joint
);
    import spr_pkg::*;

    localparam int IDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_EMIT  = 5'b10000
    } seq_state_t;

    seq_state_t           state_reg, state_next;
    stop_phase_t          phase_reg, phase_next;
    logic [STEPS_W-1:0]   count_reg, count_next;
    logic [STEPS_W-1:0]   stand_steps_reg, stand_steps_next;
    logic [STEPS_W-1:0]   down_steps_reg, down_steps_next;
    logic [STEPS_W-1:0]   steps_reg, steps_next;
    logic [STEPS_W-1:0]   n_reg, n_next;
    logic [IDX_W-1:0]     joint_reg, joint_next;
    logic [POS_WIDTH-1:0] a_reg, a_next;
    logic [POS_WIDTH-1:0] mag_reg, mag_next;
    logic                 neg_reg, neg_next;

    logic                 m_valid_reg, m_valid_next;
    logic [JIDX_W-1:0]    m_joint_reg, m_joint_next;
    logic [POS_WIDTH-1:0] m_pos_reg, m_pos_next;
    logic [PHASE_W-1:0]   m_phase_reg, m_phase_next;
    logic                 m_last_reg, m_last_next;

    // input beat fields
    req_e_t               s_req;
    logic                 s_sel;
    logic [JIDX_W-1:0]    s_joint;
    logic [POS_WIDTH-1:0] s_pos;
    logic                 in_beat;
    logic                 joint_ok;

    tbl_wr_t              tbl_wr;
    logic [POS_WIDTH-1:0] start_q, stand_q, down_q;

    logic [STEPS_W-1:0]   steps_sel, steps_eff, n_calc, count_inc;
    logic [STEPS_W:0]     count_ext;
    logic [POS_WIDTH-1:0] a_pick, b_pick;
    logic [POS_WIDTH:0]   diff, diff_abs, result;
    logic                 last_joint;

    logic                 div_start, div_done;
    logic [POS_WIDTH-1:0] div_q;

    assign s_req    = req_e_t'(s_axis_tuser[REQ_W-1:0]);
    assign s_sel    = s_axis_tuser[REQ_W];
    assign s_joint  = s_axis_tdata[JIDX_W-1:0];
    assign s_pos    = s_axis_tdata[JIDX_W+POS_WIDTH-1:JIDX_W];
    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign joint_ok = int'(s_joint) < NUM_JOINTS;

    assign s_axis_tready = (state_reg == ST_IDLE);

    // Table writes: captures only while idle, out-of-range joints dropped
    always_comb begin
        tbl_wr.en  = in_beat && joint_ok &&
                     ((s_req == REQ_CAPTURE && phase_reg == PH_IDLE) || s_req == REQ_LOAD);
        tbl_wr.tbl = (s_req == REQ_CAPTURE) ? TBL_START : (s_sel ? TBL_DOWN : TBL_STAND);
    end

    spr_pose_table #(
        .NUM_JOINTS (NUM_JOINTS),
        .POS_WIDTH  (POS_WIDTH)
    ) u_pose_table (
        .aclk    (aclk),
        .wr      (tbl_wr),
        .wr_idx  (IDX_W'(s_joint)),
        .wr_data (s_pos),
        .rd_idx  (joint_reg),
        .start_q (start_q),
        .stand_q (stand_q),
        .down_q  (down_q)
    );

    spr_divider #(
        .Q_W   (POS_WIDTH),
        .DVS_W (STEPS_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ((POS_WIDTH + STEPS_W)'(mag_reg * n_reg)),
        .divisor  (steps_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Ramp length and clamped step for the current phase; zero acts as one
    assign steps_sel = (phase_reg == PH_STAND) ? stand_steps_reg : down_steps_reg;
    assign steps_eff = (steps_sel == '0) ? STEPS_W'(1) : steps_sel;
    assign count_ext = {1'b0, count_reg} + (STEPS_W + 1)'(1);
    assign n_calc    = (count_ext > {1'b0, steps_eff}) ? steps_eff : count_ext[STEPS_W-1:0];
    assign count_inc = count_reg + STEPS_W'(1);

    always_comb begin
        unique case (phase_reg)
            PH_STAND: begin
                a_pick = start_q;
                b_pick = stand_q;
            end
            PH_DOWN: begin
                a_pick = stand_q;
                b_pick = down_q;
            end
            default: begin
                a_pick = down_q;
                b_pick = down_q;
            end
        endcase
    end

    assign diff     = {b_pick[POS_WIDTH-1], b_pick} - {a_pick[POS_WIDTH-1], a_pick};
    assign diff_abs = diff[POS_WIDTH] ? (~diff + (POS_WIDTH + 1)'(1)) : diff;
    assign result   = neg_reg ? ({a_reg[POS_WIDTH-1], a_reg} - {1'b0, div_q})
                              : ({a_reg[POS_WIDTH-1], a_reg} + {1'b0, div_q});
    assign last_joint = (joint_reg == IDX_W'(NUM_JOINTS - 1));

    always_comb begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        count_next       = count_reg;
        stand_steps_next = stand_steps_reg;
        down_steps_next  = down_steps_reg;
        steps_next       = steps_reg;
        n_next           = n_reg;
        joint_next       = joint_reg;
        a_next           = a_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        m_joint_next     = m_joint_reg;
        m_pos_next       = m_pos_reg;
        m_phase_next     = m_phase_reg;
        m_last_next      = m_last_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;
        div_start        = 1'b0;

        if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_STEPS_STAND: stand_steps_next = cfg_wr_data;
                REG_STEPS_DOWN:  down_steps_next  = cfg_wr_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    unique case (s_req)
                        REQ_TICK: begin
                            if (phase_reg != PH_IDLE) begin
                                steps_next = steps_eff;
                                n_next     = n_calc;
                                joint_next = '0;
                                state_next = ST_FETCH;
                            end
                        end
                        REQ_CAPTURE: begin
                            if (phase_reg == PH_IDLE && s_axis_tlast) begin
                                phase_next = PH_STAND;
                                count_next = '0;
                            end
                        end
                        REQ_CANCEL: begin
                            phase_next = PH_IDLE;
                            count_next = '0;
                        end
                        REQ_LOAD: ;
                        default: ;
                    endcase
                end
            end
            ST_FETCH: begin
                a_next     = a_pick;
                neg_next   = diff[POS_WIDTH];
                mag_next   = diff_abs[POS_WIDTH-1:0];
                state_next = ST_MUL;
            end
            ST_MUL: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_joint_next = JIDX_W'(joint_reg);
                    m_pos_next   = result[POS_WIDTH-1:0];
                    m_phase_next = PHASE_W'(phase_reg) - PHASE_W'(1);
                    m_last_next  = last_joint;
                    if (last_joint) begin
                        state_next = ST_IDLE;
                        if (phase_reg != PH_HOLD) begin
                            if (count_inc >= steps_reg || count_inc == '0) begin
                                phase_next = (phase_reg == PH_STAND) ? PH_DOWN : PH_HOLD;
                                count_next = '0;
                            end else begin
                                count_next = count_inc;
                            end
                        end
                    end else begin
                        joint_next = joint_reg + IDX_W'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_IDLE;
            count_reg       <= '0;
            stand_steps_reg <= STEPS_RESET;
            down_steps_reg  <= STEPS_RESET;
            joint_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            count_reg       <= count_next;
            stand_steps_reg <= stand_steps_next;
            down_steps_reg  <= down_steps_next;
            joint_reg       <= joint_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        steps_reg   <= steps_next;
        n_reg       <= n_next;
        a_reg       <= a_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        m_joint_reg <= m_joint_next;
        m_pos_reg   <= m_pos_next;
        m_phase_reg <= m_phase_next;
        m_last_reg  <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = DATA_W'({m_pos_reg, m_joint_reg});
    assign m_axis_tuser  = m_phase_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

/* sv/spr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_checker
// Port-level checks on the stop posture ramp sequencer, bound to the top.
// ----------------------------------------------------------------------------
module spr_checker #(
    parameter  int NUM_JOINTS = spr_pkg::NUM_JOINTS_DEF,
    parameter  int POS_WIDTH  = spr_pkg::POS_WIDTH_DEF,
    localparam int DATA_W     = ((spr_pkg::JIDX_W + POS_WIDTH + 7) / 8) * 8
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [2:0]                  s_axis_tuser,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [DATA_W-1:0]           m_axis_tdata,
    input logic [spr_pkg::PHASE_W-1:0] m_axis_tuser
);
    import spr_pkg::*;

    // Ready only drops after a request beat has been taken
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("ready dropped without an accepted beat");

    // Capture, cancel and load leave the input ready in the following cycle
    a_ctl_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[REQ_W-1:0] != REQ_TICK)
        |=> s_axis_tready)
        else $error("non-tick request held the input");

    a_phase_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser <= OUT_PH_HOLD))
        else $error("result beat with idle phase");

    a_joint_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (int'(m_axis_tdata[JIDX_W-1:0]) < NUM_JOINTS))
        else $error("target joint out of range");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result beat changed");

endmodule

bind stop_posture_ramp_sequencer spr_checker #(
    .NUM_JOINTS (NUM_JOINTS),
    .POS_WIDTH  (POS_WIDTH)
) u_spr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* verif/tb_stop_posture_ramp_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stop_posture_ramp_sequencer
// Self-checking bench for the stop posture ramp sequencer. A queue-fed driver
// sends request beats with random gaps. A posture predictor keeps its own
// copy of the pose tables, phase and step count, and works out the joint
// targets of every accepted tick. A monitor with random stalls compares each
// target beat with the oldest prediction. The run covers directed corner
// cases, then random capture/tick sequences under several step settings.
// ----------------------------------------------------------------------------
module tb_stop_posture_ramp_sequencer;
    import spr_pkg::*;

    localparam int NJ          = NUM_JOINTS_DEF;
    localparam int PW          = POS_WIDTH_DEF;
    localparam int DATA_W      = ((JIDX_W + PW + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 1500;

    typedef struct {
        req_e_t            req;
        logic [JIDX_W-1:0] joint;
        logic              sel;
        logic [PW-1:0]     pos;
        logic              last;
    } request_t;

    typedef struct packed {
        logic [JIDX_W-1:0]  joint;
        logic [PW-1:0]      pos;
        logic [PHASE_W-1:0] phase;
        logic               last;
    } target_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [STEPS_W-1:0]    cfg_wr_data   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata  = '0;
    logic [2:0]            s_axis_tuser  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic [PHASE_W-1:0]    m_axis_tuser;
    logic                  m_axis_tlast;

    // predictor state
    logic [STEPS_W-1:0] steps_stand_q = STEPS_RESET;
    logic [STEPS_W-1:0] steps_down_q  = STEPS_RESET;
    stop_phase_t        phase_q       = PH_IDLE;
    logic [STEPS_W-1:0] step_q        = '0;
    logic signed [PW-1:0] start_tbl [NJ];
    logic signed [PW-1:0] stand_tbl [NJ];
    logic signed [PW-1:0] down_tbl  [NJ];

    request_t request_q [$];
    target_t  target_q [$];
    request_t tx_item;
    int       tx_gap;
    bit       tx_burst;
    int       rx_stall;
    bit       rx_burst;
    int       hold_left;
    bit       hold_done;
    int       beats_in;
    int       targets_seen;
    int       mismatch_cnt;
    int       cycle_cnt;
    int       ticks_in_phase [3];

    stop_posture_ramp_sequencer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [PW-1:0] ramp_point(longint a, longint b, longint n,
                                                 longint steps);
        return PW'(a + ((b - a) * n) / steps);
    endfunction

    // Advance the posture state by one request and queue the targets it yields
    task automatic apply_request(input request_t it);
        int      steps;
        int      n;
        target_t t;
        if (it.req == REQ_CAPTURE) begin
            if (phase_q == PH_IDLE) begin
                if (it.joint < NJ) start_tbl[it.joint] = it.pos;
                if (it.last) begin
                    phase_q = PH_STAND;
                    step_q  = '0;
                end
            end
        end else if (it.req == REQ_CANCEL) begin
            phase_q = PH_IDLE;
            step_q  = '0;
        end else if (it.req == REQ_LOAD) begin
            if (it.joint < NJ) begin
                if (it.sel) down_tbl[it.joint] = it.pos;
                else        stand_tbl[it.joint] = it.pos;
            end
        end else if (phase_q != PH_IDLE) begin
            steps = (phase_q == PH_STAND) ? int'(steps_stand_q) : int'(steps_down_q);
            if (steps == 0) steps = 1;
            n = int'(step_q) + 1;
            if (n > steps) n = steps;
            ticks_in_phase[phase_q - 1]++;
            for (int j = 0; j < NJ; j++) begin
                t.joint = JIDX_W'(j);
                if (phase_q == PH_STAND)
                    t.pos = ramp_point(start_tbl[j], stand_tbl[j], n, steps);
                else if (phase_q == PH_DOWN)
                    t.pos = ramp_point(stand_tbl[j], down_tbl[j], n, steps);
                else
                    t.pos = down_tbl[j];
                t.phase = PHASE_W'(phase_q - 1);
                t.last  = (j == NJ - 1);
                target_q = {target_q, t};
            end
            if (phase_q != PH_HOLD) begin
                step_q = step_q + 1'b1;
                if (step_q >= steps || step_q == 0) begin
                    phase_q = (phase_q == PH_STAND) ? PH_DOWN : PH_HOLD;
                    step_q  = '0;
                end
            end
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            tx_gap        <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_request(tx_item);
                beats_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap != 0) begin
                    tx_gap        <= tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    tx_item = request_q.pop_front();
                    s_axis_tdata  <= DATA_W'({tx_item.pos, tx_item.joint});
                    s_axis_tuser  <= {tx_item.sel, tx_item.req};
                    s_axis_tlast  <= tx_item.last;
                    s_axis_tvalid <= 1'b1;
                    if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
                    tx_gap <= tx_burst ? 0 : $urandom_range(0, 11);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report_target(input bit unexpected, input target_t want,
                                 input target_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            if (unexpected)
                $display("Unexpected target beat %0d: joint %0d pos %0d phase %0d last %0d",
                         targets_seen, got.joint, $signed(got.pos), got.phase, got.last);
            else begin
                $display("Target beat %0d wrong: expected joint %0d pos %0d phase %0d last %0d,",
                         targets_seen, want.joint, $signed(want.pos), want.phase,
                         want.last);
                $display("    got joint %0d pos %0d phase %0d last %0d",
                         got.joint, $signed(got.pos), got.phase, got.last);
            end
        end
    endtask

    // monitor
    always @(posedge aclk) begin
        target_t got;
        target_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.joint = m_axis_tdata[JIDX_W-1:0];
                got.pos   = m_axis_tdata[JIDX_W +: PW];
                got.phase = m_axis_tuser;
                got.last  = m_axis_tlast;
                if (target_q.size() == 0) begin
                    report_target(1'b1, got, got);
                end else begin
                    want = target_q.pop_front();
                    if (got !== want) report_target(1'b0, want, got);
                end
                targets_seen++;
                if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
                rx_stall = rx_burst ? 0 : $urandom_range(0, 11);
            end else if (rx_stall != 0) begin
                rx_stall--;
            end
            m_axis_tready <= (rx_stall == 0) && (hold_left == 0);
        end
    end

    // one long receiver hold-off, so the block backs up onto its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && targets_seen >= 400) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_cnt);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [PW-1:0] rand_pos();
        case ($urandom_range(0, 7))
            0:       return {1'b0, {(PW-1){1'b1}}};
            1:       return {1'b1, {(PW-1){1'b0}}};
            default: return PW'($urandom());
        endcase
    endfunction

    task automatic queue_req(input req_e_t req, input int joint, input logic sel,
                             input logic [PW-1:0] pos, input logic last);
        request_t it;
        it.req   = req;
        it.joint = JIDX_W'(joint);
        it.sel   = sel;
        it.pos   = pos;
        it.last  = last;
        request_q = {request_q, it};
    endtask

    task automatic queue_tick();
        queue_req(REQ_TICK, 0, 1'b0, '0, 1'b0);
    endtask

    // hold until every request is in and every target is out
    task automatic wait_quiet();
        while (request_q.size() != 0 || s_axis_tvalid || target_q.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_steps(input cfg_reg_t idx, input logic [STEPS_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        if (idx == REG_STEPS_STAND) steps_stand_q = val;
        else                        steps_down_q  = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_run(input int n_items);
        int sent;
        int k;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                // well-formed: an optional cancel, capture every joint, then a burst of ticks with occasional loads
                if ($urandom_range(0, 3) != 0) begin
                    queue_req(REQ_CANCEL, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                              rand_pos(), 1'($urandom_range(0, 1)));
                    sent++;
                end
                for (int j = 0; j < NJ; j++)
                    queue_req(REQ_CAPTURE, j, 1'($urandom_range(0, 1)), rand_pos(),
                              j == NJ - 1);
                sent += NJ;
                k = $urandom_range(1, 16);
                repeat (k) begin
                    if ($urandom_range(0, 7) == 0) begin
                        queue_req(REQ_LOAD, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                                  rand_pos(), 1'($urandom_range(0, 1)));
                        sent++;
                    end
                    queue_req(REQ_TICK, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                              rand_pos(), 1'($urandom_range(0, 1)));
                    sent++;
                end
            end else begin
                queue_req(req_e_t'($urandom_range(0, 3)), $urandom_range(0, 15),
                          1'($urandom_range(0, 1)), rand_pos(), 1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    logic [STEPS_W-1:0] stand_set [6] = '{16'd1, 16'd0, 16'd3, 16'hFFFF, 16'd0, 16'd16};
    logic [STEPS_W-1:0] down_set  [6] = '{16'd1, 16'd0, 16'd5, 16'hFFFF, 16'd0, 16'd2};

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // fill the stand and down pose tables with full-scale swings
        for (int j = 0; j < NJ; j++) begin
            queue_req(REQ_LOAD, j, 1'b0, j[0] ? 16'h8000 : 16'h7FFF, 1'b0);
            queue_req(REQ_LOAD, j, 1'b1, j[0] ? 16'h7FFF : 16'h8000, 1'b0);
        end
        queue_tick();                                   // tick while idle
        queue_req(REQ_TICK, 0, 1'b0, '0, 1'b1);         // capture_last on a tick
        queue_req(REQ_CAPTURE, 15, 1'b0, 16'h1234, 1'b0);  // joint out of range
        for (int j = 0; j < NJ; j++)
            queue_req(REQ_CAPTURE, j, 1'b0, j[0] ? 16'h7FFF : 16'h8000, j == NJ - 1);
        queue_tick();
        queue_tick();
        queue_req(REQ_CAPTURE, 3, 1'b0, 16'h0000, 1'b1);   // ignored while running
        queue_req(REQ_LOAD, 12, 1'b1, 16'h0001, 1'b0);     // out of range
        queue_req(REQ_LOAD, 15, 1'b0, 16'hFFFF, 1'b1);
        queue_tick();
        queue_req(REQ_CANCEL, 0, 1'b0, '0, 1'b0);
        wait_quiet();

        // single-step ramps, right through to hold
        write_steps(REG_STEPS_STAND, 16'd1);
        write_steps(REG_STEPS_DOWN, 16'd1);
        queue_req(REQ_CAPTURE, 0, 1'b0, 16'h8000, 1'b1);
        repeat (4) queue_tick();
        queue_req(REQ_CANCEL, 0, 1'b0, '0, 1'b1);
        queue_tick();
        wait_quiet();

        // zero acts as one; longest ramp
        write_steps(REG_STEPS_STAND, 16'd0);
        write_steps(REG_STEPS_DOWN, 16'hFFFF);
        queue_req(REQ_CAPTURE, 14, 1'b0, 16'h0000, 1'b1);
        repeat (3) queue_tick();
        queue_req(REQ_CANCEL, 0, 1'b0, '0, 1'b0);
        wait_quiet();

        // lower the step counts while a ramp is under way
        write_steps(REG_STEPS_STAND, 16'd100);
        write_steps(REG_STEPS_DOWN, 16'd100);
        queue_req(REQ_CAPTURE, 0, 1'b0, 16'h4000, 1'b1);
        repeat (3) queue_tick();
        wait_quiet();
        write_steps(REG_STEPS_STAND, 16'd2);
        repeat (2) queue_tick();
        wait_quiet();
        write_steps(REG_STEPS_DOWN, 16'd1);
        repeat (2) queue_tick();
        queue_req(REQ_CANCEL, 0, 1'b0, '0, 1'b0);

        for (int p = 0; p < 6; p++) begin
            wait_quiet();
            write_steps(REG_STEPS_STAND,
                        (p == 4) ? STEPS_W'($urandom_range(1, 12)) : stand_set[p]);
            write_steps(REG_STEPS_DOWN,
                        (p == 4) ? STEPS_W'($urandom_range(1, 12)) : down_set[p]);
            random_run(32);
        end

        wait_quiet();
        repeat (300) @(posedge aclk);
        if (target_q.size() != 0) begin
            $display("%0d expected targets never arrived", target_q.size());
            mismatch_cnt += target_q.size();
        end
        $display("Sent %0d request beats, checked %0d target beats", beats_in, targets_seen);
        $display("Ticks by phase: to_stand %0d, to_down %0d, hold %0d",
                 ticks_in_phase[0], ticks_in_phase[1], ticks_in_phase[2]);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
